// ===== sv/perl_pkg.sv =====
`default_nettype none
package perl_pkg;

	localparam int TABLE_AW    = 8;
	localparam int TABLE_SIZE  = 1 << TABLE_AW;
	localparam int MAX_OCTAVES = 8;
	localparam int OCT_W       = 4;
	localparam int COORD_BITS  = 12;
	localparam int MUL_W       = 26;
	localparam int PROD_W      = 2 * MUL_W;

	localparam logic [1:0] CFG_OCTAVES = 2'd0;
	localparam logic [1:0] CFG_FREQ    = 2'd1;
	localparam logic [1:0] CFG_WIDTH   = 2'd2;
	localparam logic [1:0] CFG_HEIGHT  = 2'd3;

	localparam logic [OCT_W-1:0] RST_OCTAVES = 4'd8;
	localparam logic [23:0]      RST_FREQ    = 24'd83886;
	localparam logic [12:0]      RST_WIDTH   = 13'd256;
	localparam logic [12:0]      RST_HEIGHT  = 13'd256;

	typedef struct packed {
		logic [OCT_W-1:0] octave_count;
		logic [23:0]      base_frequency;
	} perl_cfg_t;

	typedef struct packed {
		logic                  load;
		logic [TABLE_AW-1:0]   table_index;
		logic [7:0]            table_value;
		logic                  start;
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic                  ack;
	} perl_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] gray;
	} perl_rsp_t;

endpackage
`default_nettype wire

// ===== sv/perl_mul.sv =====
`default_nettype none
module perl_mul
	import perl_pkg::*;
(
	input  wire                     clk,
	input  wire signed [MUL_W-1:0]  a,
	input  wire signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule
`default_nettype wire

// ===== sv/perl_core.sv =====
`default_nettype none
module perl_core
	import perl_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  perl_cfg_t cfg,
	input  perl_req_t req,
	output perl_rsp_t rsp
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_PX   = 5'd1;
	localparam logic [4:0] ST_PY   = 5'd2;
	localparam logic [4:0] ST_O0   = 5'd3;
	localparam logic [4:0] ST_O1   = 5'd4;
	localparam logic [4:0] ST_O2   = 5'd5;
	localparam logic [4:0] ST_O3   = 5'd6;
	localparam logic [4:0] ST_O4   = 5'd7;
	localparam logic [4:0] ST_O5   = 5'd8;
	localparam logic [4:0] ST_O6   = 5'd9;
	localparam logic [4:0] ST_O7   = 5'd10;
	localparam logic [4:0] ST_O8   = 5'd11;
	localparam logic [4:0] ST_O9   = 5'd12;
	localparam logic [4:0] ST_O10  = 5'd13;
	localparam logic [4:0] ST_O11  = 5'd14;
	localparam logic [4:0] ST_O12  = 5'd15;
	localparam logic [4:0] ST_FIN  = 5'd16;
	localparam logic [4:0] ST_DONE = 5'd17;

	localparam logic [20:0] FADE_P = 21'd983040;
	localparam logic [20:0] FADE_R = 21'd655360;
	localparam logic signed [19:0] ONE_Q16 = 20'sd65536;
	localparam logic signed [21:0] SUM_MAX = 22'sd524287;
	localparam logic signed [21:0] SUM_MIN = -22'sd524288;

	function automatic logic signed [19:0] grad_dot(input logic [1:0] h,
		input logic signed [19:0] dx, input logic signed [19:0] dy);
		logic signed [19:0] r;
		unique case (h)
			2'd0: r = dx + dy;
			2'd1: r = dy - dx;
			2'd2: r = -dx - dy;
			default: r = dx - dy;
		endcase
		return r;
	endfunction

	logic [7:0] perm_mem [TABLE_SIZE];
	logic [7:0] rd_q;
	logic [TABLE_AW-1:0] rd_addr;

	logic [4:0]            step_q;
	logic [OCT_W-1:0]      oct_q;
	logic [OCT_W-1:0]      oct_lim;
	logic [COORD_BITS-1:0] row_q;
	logic [31:0]           sx_q, sy_q;
	logic [7:0]            px0_q, px1_q;
	logic [1:0]            hbl_q, htl_q, hbr_q, htr_q;
	logic [15:0]           t3_q;
	logic [16:0]           u_q, v_q;
	logic signed [19:0]    a0_q, a1_q, sum_q;
	logic [7:0]            gray_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;

	logic [7:0]  xi, yi;
	logic [15:0] xf, yf, t;
	logic [20:0] fade_p, fade_r;
	logic signed [19:0] dx0, dx1, dy0, dy1, dbl, dtl, dbr, dtr;
	logic signed [21:0] lerp_d, noise_n, noise_w, sum_w;
	logic signed [20:0] gray_v;
	logic [27:0] gray_m;

	assign xi = sx_q[31:24];
	assign xf = sx_q[23:8];
	assign yi = sy_q[31:24];
	assign yf = sy_q[23:8];
	assign t  = (step_q <= ST_O3) ? xf : yf;

	assign fade_p = FADE_P - ({5'd0, t} << 2) - ({5'd0, t} << 1);
	assign fade_r = FADE_R - {1'b0, prod_q[35:16]};

	assign dx0 = signed'({4'd0, xf});
	assign dy0 = signed'({4'd0, yf});
	assign dx1 = dx0 - ONE_Q16;
	assign dy1 = dy0 - ONE_Q16;
	assign dbl = grad_dot(hbl_q, dx0, dy0);
	assign dtl = grad_dot(htl_q, dx0, dy1);
	assign dbr = grad_dot(hbr_q, dx1, dy0);
	assign dtr = grad_dot(htr_q, dx1, dy1);

	assign lerp_d  = signed'(prod_q[37:16]);
	assign noise_n = 22'(a0_q) + lerp_d;
	assign noise_w = noise_n >>> oct_q;
	assign sum_w   = 22'(sum_q) + noise_w;

	assign gray_v = 21'(sum_q) + 21'(ONE_Q16);
	assign gray_m = {gray_v[19:0], 8'd0} - {8'd0, gray_v[19:0]};

	assign oct_lim = (cfg.octave_count > OCT_W'(MAX_OCTAVES)) ?
		OCT_W'(MAX_OCTAVES) : cfg.octave_count;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			ST_IDLE: begin
				mul_a = signed'(MUL_W'(req.col));
				mul_b = signed'(MUL_W'(cfg.base_frequency));
			end
			ST_PX: begin
				mul_a = signed'(MUL_W'(row_q));
				mul_b = signed'(MUL_W'(cfg.base_frequency));
			end
			ST_O0, ST_O4: begin
				mul_a = signed'(MUL_W'(t));
				mul_b = signed'(MUL_W'(t));
			end
			ST_O1, ST_O5: begin
				mul_a = signed'(MUL_W'(prod_q[31:16]));
				mul_b = signed'(MUL_W'(t));
			end
			ST_O2, ST_O6: begin
				mul_a = signed'(MUL_W'(fade_p));
				mul_b = signed'(MUL_W'(t));
			end
			ST_O3, ST_O7: begin
				mul_a = signed'(MUL_W'(fade_r));
				mul_b = signed'(MUL_W'(t3_q));
			end
			ST_O8: begin
				mul_a = signed'(MUL_W'(prod_q[32:16]));
				mul_b = MUL_W'(21'(dtl) - 21'(dbl));
			end
			ST_O9: begin
				mul_a = signed'(MUL_W'(v_q));
				mul_b = MUL_W'(21'(dtr) - 21'(dbr));
			end
			ST_O11: begin
				mul_a = signed'(MUL_W'(u_q));
				mul_b = MUL_W'(21'(a1_q) - 21'(a0_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	perl_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	always_comb begin
		unique case (step_q)
			ST_O1:   rd_addr = xi + 8'd1;
			ST_O2:   rd_addr = px0_q + yi;
			ST_O3:   rd_addr = px0_q + yi + 8'd1;
			ST_O4:   rd_addr = px1_q + yi;
			ST_O5:   rd_addr = px1_q + yi + 8'd1;
			default: rd_addr = xi;
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			perm_mem[req.table_index] <= req.table_value;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= perm_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		unique case (step_q)
			ST_IDLE: begin
				row_q <= req.row;
				sum_q <= '0;
			end
			ST_PX: sx_q <= prod_q[31:0];
			ST_PY: sy_q <= prod_q[31:0];
			ST_O1: px0_q <= rd_q;
			ST_O2: begin
				px1_q <= rd_q;
				t3_q  <= prod_q[31:16];
			end
			ST_O3: hbl_q <= rd_q[1:0];
			ST_O4: begin
				htl_q <= rd_q[1:0];
				u_q   <= prod_q[32:16];
			end
			ST_O5: hbr_q <= rd_q[1:0];
			ST_O6: begin
				htr_q <= rd_q[1:0];
				t3_q  <= prod_q[31:16];
			end
			ST_O8:  v_q  <= prod_q[32:16];
			ST_O9:  a0_q <= 20'(22'(dbl) + lerp_d);
			ST_O10: a1_q <= 20'(22'(dbr) + lerp_d);
			ST_O12: begin
				if (sum_w > SUM_MAX) begin
					sum_q <= 20'(SUM_MAX);
				end else if (sum_w < SUM_MIN) begin
					sum_q <= 20'(SUM_MIN);
				end else begin
					sum_q <= 20'(sum_w);
				end
				sx_q <= sx_q << 1;
				sy_q <= sy_q << 1;
			end
			ST_FIN: begin
				if (gray_v <= 21'sd0) begin
					gray_q <= 8'd0;
				end else if (gray_m[27:17] > 11'd255) begin
					gray_q <= 8'd255;
				end else begin
					gray_q <= gray_m[24:17];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			oct_q  <= '0;
		end else begin
			unique case (step_q)
				ST_IDLE: begin
					oct_q <= '0;
					if (req.start) begin
						step_q <= ST_PX;
					end
				end
				ST_PX: step_q <= ST_PY;
				ST_PY: step_q <= (oct_lim == '0) ? ST_FIN : ST_O0;
				ST_O12: begin
					oct_q  <= oct_q + 1'b1;
					step_q <= (oct_q + 1'b1 == oct_lim) ? ST_FIN : ST_O0;
				end
				ST_FIN: step_q <= ST_DONE;
				ST_DONE: begin
					if (req.ack) begin
						step_q <= ST_IDLE;
					end
				end
				ST_O0, ST_O1, ST_O2, ST_O3, ST_O4, ST_O5, ST_O6, ST_O7, ST_O8, ST_O9,
				ST_O10, ST_O11: step_q <= step_q + 5'd1;
				default: step_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.done = (step_q == ST_DONE);
	assign rsp.gray = gray_q;

endmodule
`default_nettype wire

// ===== sv/perlin_fbm_gray_raster.sv =====
// Grayscale raster of two-dimensional Perlin noise summed over octaves.
// Input channel (in_valid/in_stall): cmd 0 writes table_value into entry
// table_index of the permutation table; cmd 1 requests the next
// pixel of the raster, which walks the columns and then the lines.
// The whole table must be loaded before the first pixel request.
// Output channel (out_valid/out_stall): one result per pixel request, with
// its gray level, position and end of row and end of frame flags.
// Configuration channel (cfg_valid/cfg_ready): cfg_ready is always high;
// write only while no pixel request is outstanding.
// A pixel request is computed on the single shared multiplier, which runs
// the fade, lerp and coordinate products in turn.
// in_stall is high while a pixel is being computed. The finished pixel moves
// into the output register, so the next request is taken while it waits.
// If the receiver stalls and a second pixel finishes, it is held back and
// in_stall stays high until the output register frees up.
// Reset clears the raster position and loads the default registers; the
// table contents are left undefined.
`default_nettype none
module perlin_fbm_gray_raster
	import perl_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        cmd,
	input  wire [7:0]  table_index,
	input  wire [7:0]  table_value,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0]  gray,
	output logic [11:0] column,
	output logic [11:0] line,
	output logic        end_of_row,
	output logic        end_of_frame,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [1:0]  cfg_index,
	input  wire [23:0] cfg_data
);

	localparam logic [12:0] COORD_LIM = 13'(1 << COORD_BITS);

	logic [OCT_W-1:0] octave_count_q;
	logic [23:0]      base_frequency_q;
	logic [12:0]      image_width_q, image_height_q;
	logic [COORD_BITS-1:0] col_q, row_q;
	logic busy_q;
	logic out_valid_q;
	logic [COORD_BITS-1:0] pix_col_q, pix_row_q;
	logic pix_eor_q, pix_eof_q;

	logic [12:0] w_eff, h_eff;
	logic eor, eof, accept, start, out_free;
	perl_cfg_t cfg;
	perl_req_t req;
	perl_rsp_t rsp;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy_q;
	assign accept    = in_valid && !busy_q;
	assign start     = accept && cmd;
	assign out_free  = !out_valid_q || !out_stall;

	assign w_eff = (image_width_q == '0) ? 13'd1 :
		((image_width_q > COORD_LIM) ? COORD_LIM : image_width_q);
	assign h_eff = (image_height_q == '0) ? 13'd1 :
		((image_height_q > COORD_LIM) ? COORD_LIM : image_height_q);
	assign eor = ({1'b0, col_q} + 13'd1) >= w_eff;
	assign eof = eor && (({1'b0, row_q} + 13'd1) >= h_eff);

	assign cfg.octave_count   = octave_count_q;
	assign cfg.base_frequency = base_frequency_q;

	assign req.load        = accept && !cmd;
	assign req.table_index = table_index[TABLE_AW-1:0];
	assign req.table_value = table_value;
	assign req.start       = start;
	assign req.col         = col_q;
	assign req.row         = row_q;
	assign req.ack         = rsp.done && out_free;

	perl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q   <= RST_OCTAVES;
			base_frequency_q <= RST_FREQ;
			image_width_q    <= RST_WIDTH;
			image_height_q   <= RST_HEIGHT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OCTAVES: octave_count_q   <= cfg_data[OCT_W-1:0];
				CFG_FREQ:    base_frequency_q <= cfg_data;
				CFG_WIDTH:   image_width_q    <= cfg_data[12:0];
				CFG_HEIGHT:  image_height_q   <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				if (eor) begin
					col_q <= '0;
					row_q <= eof ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (req.ack) begin
				busy_q <= 1'b0;
			end
			if (req.ack) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pix_col_q <= col_q;
			pix_row_q <= row_q;
			pix_eor_q <= eor;
			pix_eof_q <= eof;
		end
		if (req.ack) begin
			gray         <= rsp.gray;
			column       <= pix_col_q;
			line         <= pix_row_q;
			end_of_row   <= pix_eor_q;
			end_of_frame <= pix_eof_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== sv/perl_checker.sv =====
`default_nettype none
module perl_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        cmd,
	input wire        out_valid,
	input wire        out_stall,
	input wire [7:0]  gray,
	input wire [11:0] column,
	input wire [11:0] line,
	input wire        end_of_row,
	input wire        end_of_frame
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(gray) && $stable(column)
			&& $stable(line))
		else $error("stalled result changed");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> end_of_row)
		else $error("end of frame without end of row");

	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd |=> in_stall)
		else $error("pixel request did not make the block busy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !cmd |=> !in_stall)
		else $error("table load made the block busy");

endmodule

bind perlin_fbm_gray_raster perl_checker u_checker (.*);
`default_nettype wire
